// ===== rtl/nphe_pkg.sv =====
`timescale 1ns / 1ps
// Package for the NAND page Hamming ECC generator.
// Parity word type, preset value and column parity masks. No dependencies.
package nphe_pkg;

  localparam int unsigned PARITY_W  = 24;
  localparam int unsigned LINE_BASE = 6;   // first line parity bit
  localparam int unsigned NUM_COL   = 6;

  typedef logic [PARITY_W-1:0] parity_t;
  typedef logic [7:0]          byte_t;

  localparam parity_t PARITY_PRESET = {PARITY_W{1'b1}};

  // Column parity k folds the byte bits selected by COL_MASK[k]
  localparam byte_t COL_MASK [NUM_COL] = '{
    8'h55, 8'hAA, 8'h33, 8'hCC, 8'h0F, 8'hF0
  };

endpackage

// ===== rtl/nand_page_hamming_ecc_generator.sv =====
`timescale 1ns / 1ps
// Top level: NAND page Hamming ECC generator (inverted SmartMedia style code).
// Depends on nphe_pkg for the parity type, preset and column masks.

// One data word is taken per clock, save that a page's last word is held off
// while the result is stalled; the only stage is the parity/index register,
// updated by a few levels of XOR straight from the input word. Six column
// parities come from fixed bit masks of each byte; 2*INDEX_BITS line parities
// steer the byte's overall parity by each bit of the running byte index. The
// word flagged with in_last_byte is folded in, and the three packed ECC bytes
// appear in the output register on the next cycle; the parities are then
// preset to one and the index cleared, so the next page may start on that
// very cycle. The output register holds one result: while it is full and
// stalled, only a word carrying in_last_byte is held off (in_stall), other
// words keep flowing. The index wraps modulo 2^INDEX_BITS; with INDEX_BITS of
// 8 the two top line parities are never touched and read as one.
module nand_page_hamming_ecc_generator #(
  parameter int unsigned INDEX_BITS = 9
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_ecc_first,
  output logic [7:0] out_ecc_second,
  output logic [7:0] out_ecc_third
);

  nphe_pkg::parity_t       parity_r, parity_nxt, parity_upd;
  logic [INDEX_BITS-1:0]   byte_idx_r, byte_idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [7:0]              ecc_first_r, ecc_second_r, ecc_third_r;
  logic                    in_acc;
  logic                    out_busy;
  logic                    whole;

  // result register full and not being drained this cycle
  assign out_busy = out_valid_r & out_stall;
  assign in_stall = out_busy & in_last_byte;
  assign in_acc   = in_valid & ~in_stall;

  // parity update for the incoming word
  always_comb begin
    parity_upd = parity_r;
    whole      = ^in_data_byte;
    for (int k = 0; k < nphe_pkg::NUM_COL; k++) begin
      parity_upd[k] = parity_r[k] ^ (^(in_data_byte & nphe_pkg::COL_MASK[k]));
    end
    // line parity pair k: even slot if index bit k is 0, odd slot if 1
    for (int k = 0; k < INDEX_BITS; k++) begin
      if (byte_idx_r[k]) begin
        parity_upd[nphe_pkg::LINE_BASE + 2*k + 1] =
          parity_r[nphe_pkg::LINE_BASE + 2*k + 1] ^ whole;
      end else begin
        parity_upd[nphe_pkg::LINE_BASE + 2*k] =
          parity_r[nphe_pkg::LINE_BASE + 2*k] ^ whole;
      end
    end
  end

  always_comb begin
    parity_nxt    = parity_r;
    byte_idx_nxt  = byte_idx_r;
    out_valid_nxt = out_busy;
    if (in_acc) begin
      if (in_last_byte) begin
        parity_nxt    = nphe_pkg::PARITY_PRESET;
        byte_idx_nxt  = '0;
        out_valid_nxt = 1'b1;
      end else begin
        parity_nxt   = parity_upd;
        byte_idx_nxt = byte_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r    <= nphe_pkg::PARITY_PRESET;
      byte_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      parity_r    <= parity_nxt;
      byte_idx_r  <= byte_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // packed ECC bytes, loaded only with the last word of a page
  always_ff @(posedge clk) begin
    if (in_acc && in_last_byte) begin
      ecc_first_r  <= parity_upd[21:14];
      ecc_second_r <= parity_upd[13:6];
      ecc_third_r  <= {parity_upd[5:0], parity_upd[23], parity_upd[22]};
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ecc_first  = ecc_first_r;
  assign out_ecc_second = ecc_second_r;
  assign out_ecc_third  = ecc_third_r;

  // last word always yields a result and restarts the page
  a_last_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last_byte |=> out_valid_r && byte_idx_r == '0 &&
                               parity_r == nphe_pkg::PARITY_PRESET)
    else $error("last word did not produce a result or restart the page");

  a_index_steps : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_last_byte |=> byte_idx_r == INDEX_BITS'($past(byte_idx_r) + 1'b1))
    else $error("byte index did not advance by one");

  a_idle_holds : assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(parity_r) && $stable(byte_idx_r))
    else $error("parity state changed without an accepted word");

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(ecc_first_r) &&
                                 $stable(ecc_second_r) && $stable(ecc_third_r))
    else $error("pending ECC result overwritten or dropped");

endmodule

// ===== sim/nand_page_hamming_ecc_generator_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for nand_page_hamming_ecc_generator.
// Streams pages of bytes through the block and checks each packed ECC word
// against an in-bench parity predictor. Needs only the RTL and its package.
module nand_page_hamming_ecc_generator_test;

  localparam int unsigned IDX_W       = 9;       // default index width of the block
  localparam int          TARGET      = 1550;    // data words to queue
  localparam int          CYCLE_LIMIT = 500000;  // hard stop, well above the slowest run
  localparam int          HOLD_AT     = 1000;    // words taken before the long hold-off
  localparam int          HOLD_LEN    = 400;     // cycles of the long hold-off
  localparam int          TAIL        = 20;      // cycles to idle after the last ECC word

  // Own copy of the column masks: parity k folds the byte bits under mask k
  localparam logic [7:0] COLUMN_MASK [6] = '{
    8'h55, 8'hAA, 8'h33, 8'hCC, 8'h0F, 8'hF0
  };

  // Ways of filling a page's data words
  typedef enum int {FILL_ERASED, FILL_ZERO, FILL_RANDOM} page_fill_t;

  typedef struct {
    logic [7:0] data;
    logic       is_last;
    bit         drain_first;  // sender waits for every ECC word before offering this one
  } page_word_t;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] third;
  } ecc_word_t;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte   = 8'h00;
  logic       in_last_byte   = 1'b0;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic [7:0] out_ecc_first;
  logic [7:0] out_ecc_second;
  logic [7:0] out_ecc_third;

  page_word_t      pending_words[$];
  ecc_word_t       ecc_expected[$];

  // Predictor state: running parities (preset to one) and byte index
  logic [23:0]     page_parity = '1;
  logic [IDX_W-1:0] byte_pos   = '0;

  int  words_taken  = 0;
  int  mismatches   = 0;
  int  queued_words = 0;
  int  cycle_count  = 0;
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;
  bit  calm         = 1'b0;  // when set neither side adds random pauses
  int  send_gap     = 0;
  int  stall_left   = 0;

  nand_page_hamming_ecc_generator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ecc_first  (out_ecc_first),
    .out_ecc_second (out_ecc_second),
    .out_ecc_third  (out_ecc_third)
  );

  always #5 clk = ~clk;

  // Idle length: mostly none, some short, the odd long one; none in calm stretches
  function automatic int pick_pause();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Fold one accepted word into the predicted parities; on the last word of a
  // page, pack the ECC word, queue it and preset the state for the next page.
  task automatic fold_word(input logic [7:0] data, input logic is_last);
    ecc_word_t code;
    logic      whole;
    for (int k = 0; k < 6; k++) begin
      page_parity[k] ^= ^(data & COLUMN_MASK[k]);
    end
    // line parities: index bit k steers the byte parity to 6+2k or 7+2k
    whole = ^data;
    for (int k = 0; k < IDX_W; k++) begin
      page_parity[6 + 2*k + byte_pos[k]] ^= whole;
    end
    byte_pos = byte_pos + 1'b1;  // wraps past the top of the index range
    if (is_last) begin
      code.first  = page_parity[21:14];
      code.second = page_parity[13:6];
      code.third  = {page_parity[5:0], page_parity[23], page_parity[22]};
      ecc_expected.push_back(code);
      page_parity = '1;
      byte_pos    = '0;
    end
  endtask

  task automatic queue_word(input logic [7:0] data, input logic is_last,
                            input bit drain_first);
    page_word_t w;
    w.data        = data;
    w.is_last     = is_last;
    w.drain_first = drain_first;
    pending_words.push_back(w);
    queued_words++;
  endtask

  task automatic queue_page(input int len, input page_fill_t fill, input bit drain_first);
    logic [7:0] d;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ERASED: d = 8'hFF;
        FILL_ZERO:   d = 8'h00;
        default:     d = 8'($urandom);
      endcase
      queue_word(d, i == len - 1, drain_first && i == 0);
    end
  endtask

  // Sender: offers words from the pending queue, holds a stalled word steady,
  // and feeds each accepted word to the predictor.
  always @(posedge clk) begin
    page_word_t w;
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_data_byte <= 8'h00;
      in_last_byte <= 1'b0;
      send_gap      = 0;
    end else begin
      if (in_valid && !in_stall) begin
        fold_word(in_data_byte, in_last_byte);
        words_taken++;
        if (words_taken % 128 == 0) calm = ($urandom_range(3) == 0);
      end
      // a word still stalled stays on the bus unchanged
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (pending_words.size() > 0 &&
                     !(pending_words[0].drain_first && ecc_expected.size() > 0)) begin
          w = pending_words.pop_front();
          in_valid     <= 1'b1;
          in_data_byte <= w.data;
          in_last_byte <= w.is_last;
          send_gap      = pick_pause();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the block fills and stalls its input
  always @(posedge clk) begin
    if (rst_n && !hold_done && words_taken >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: random stalls, checks each accepted ECC word against the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    ecc_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (ecc_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ECC word with none expected: %h %h %h",
                     out_ecc_first, out_ecc_second, out_ecc_third);
        end else begin
          want = ecc_expected.pop_front();
          if (out_ecc_first !== want.first || out_ecc_second !== want.second ||
              out_ecc_third !== want.third) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ECC mismatch: expected %h %h %h, got %h %h %h",
                       want.first, want.second, want.third,
                       out_ecc_first, out_ecc_second, out_ecc_third);
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_pause();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int len;
    int page_no;
    page_fill_t fill;

    // Directed: single-byte pages at the extremes
    queue_word(8'h00, 1'b1, 1'b0);
    queue_word(8'hFF, 1'b1, 1'b0);
    queue_word(8'h01, 1'b1, 1'b0);
    queue_word(8'h80, 1'b1, 1'b0);
    // each column mask as a data word, one page
    for (int k = 0; k < 6; k++) queue_word(COLUMN_MASK[k], k == 5, 1'b0);
    // walking one across a page of eight
    for (int k = 0; k < 8; k++) queue_word(8'(1 << k), k == 7, 1'b0);
    queue_word(8'h00, 1'b0, 1'b0);
    queue_word(8'hFF, 1'b1, 1'b0);

    // Random pages, mostly short; one runs past the index range so it wraps.
    // Two pages start only once every ECC word so far has come out.
    page_no = 0;
    while (queued_words < TARGET) begin
      if (page_no == 12) len = 600;
      else if ($urandom_range(15) == 0) len = $urandom_range(40, 160);
      else len = $urandom_range(1, 24);
      case ($urandom_range(9))
        0:       fill = FILL_ERASED;
        1:       fill = FILL_ZERO;
        default: fill = FILL_RANDOM;
      endcase
      queue_page(len, fill, page_no == 20 || page_no == 45);
      page_no++;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (ecc_expected.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    if (mismatches == 0 && ecc_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
